// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for the concurrent checks of the filter block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked at every rising edge while out of reset.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// A condition that must be followed by another in the next cycle.
`define ASSERT_NEXT(label, clk, rstn, cond, nxt, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (nxt)) \
        else $error(msg);

`endif

// ===== hw/rtl/iirdf_pkg.sv =====
// ----------------------------------------------------------------------------
// iirdf_pkg
// Shared constants and types of the direct-form IIR filter.
// ----------------------------------------------------------------------------
package iirdf_pkg;

    localparam int MAX_ORDER_DEF = 16;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_ZEROS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_NUM_POLES = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_INV_GAIN  = CFG_IDX_W'(2);

    localparam logic [31:0] INV_GAIN_RESET = 32'h0100_0000;

    typedef enum logic [1:0] {
        OP_SAMPLE  = 2'd0,
        OP_ZERO_WR = 2'd1,
        OP_POLE_WR = 2'd2,
        OP_CLEAR   = 2'd3
    } opcode_t;

    typedef struct packed {
        logic hist_clear;
        logic zero_wr;
        logic pole_wr;
        logic scale_mul;
        logic shift_hist;
        logic acc_clear;
        logic tap_mul;
        logic tap_sel_pole;
        logic finish;
    } ctrl_cmd_t;

endpackage

// ===== hw/rtl/iirdf_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// iirdf_cfg_regs
// Configuration registers and the clamped filter orders derived from them.
// ----------------------------------------------------------------------------
module iirdf_cfg_regs
    import iirdf_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF,
    localparam int IDX_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic [IDX_W-1:0]      nz_eff,
    output logic [IDX_W-1:0]      np_eff,
    output logic signed [31:0]    inv_gain
);

    localparam int EXT_W = IDX_W + 4;

    logic [3:0]       num_zeros_reg;
    logic [3:0]       num_poles_reg;
    logic [31:0]      inv_gain_reg;
    logic [EXT_W-1:0] nz_ext;
    logic [EXT_W-1:0] np_ext;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_zeros_reg <= '0;
            num_poles_reg <= '0;
            inv_gain_reg  <= INV_GAIN_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_NUM_ZEROS: num_zeros_reg <= cfg_data[3:0];
                REG_NUM_POLES: num_poles_reg <= cfg_data[3:0];
                REG_INV_GAIN:  inv_gain_reg  <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // Orders beyond the history depth act as the deepest usable tap.
    assign nz_ext = EXT_W'(num_zeros_reg);
    assign np_ext = EXT_W'(num_poles_reg);
    assign nz_eff = (nz_ext > EXT_W'(MAX_ORDER - 1)) ? IDX_W'(MAX_ORDER - 1)
                                                      : nz_ext[IDX_W-1:0];
    assign np_eff = (np_ext > EXT_W'(MAX_ORDER - 1)) ? IDX_W'(MAX_ORDER - 1)
                                                      : np_ext[IDX_W-1:0];
    assign inv_gain = inv_gain_reg;

endmodule

// ===== hw/rtl/iirdf_ctrl.sv =====
// ----------------------------------------------------------------------------
// iirdf_ctrl
// Sequencer that steps the shared multiply-accumulate unit over the taps.
// ----------------------------------------------------------------------------
module iirdf_ctrl
    import iirdf_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF,
    localparam int IDX_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       opcode,
    input  logic [IDX_W-1:0] nz_eff,
    input  logic [IDX_W-1:0] np_eff,
    input  logic             out_hold,
    output ctrl_cmd_t        cmd,
    output logic [IDX_W-1:0] tap_idx
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SHIFT  = 5'b00010,
        ST_MAC    = 5'b00100,
        ST_DRAIN  = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic             pole_reg, pole_next;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pole_next  = pole_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    unique case (opcode_t'(opcode))
                        OP_SAMPLE: begin
                            cmd.scale_mul = 1'b1;
                            state_next    = ST_SHIFT;
                        end
                        OP_ZERO_WR: cmd.zero_wr    = 1'b1;
                        OP_POLE_WR: cmd.pole_wr    = 1'b1;
                        OP_CLEAR:   cmd.hist_clear = 1'b1;
                    endcase
                end
            end
            ST_SHIFT: begin
                cmd.shift_hist = 1'b1;
                cmd.acc_clear  = 1'b1;
                cnt_next       = '0;
                pole_next      = 1'b0;
                state_next     = ST_MAC;
            end
            ST_MAC: begin
                cmd.tap_mul      = 1'b1;
                cmd.tap_sel_pole = pole_reg;
                if (!pole_reg) begin
                    if (cnt_reg == nz_eff) begin
                        if (np_eff == '0) begin
                            state_next = ST_DRAIN;
                        end else begin
                            pole_next = 1'b1;
                            cnt_next  = '0;
                        end
                    end else begin
                        cnt_next = cnt_reg + IDX_W'(1);
                    end
                end else if (cnt_reg == np_eff - IDX_W'(1)) begin
                    state_next = ST_DRAIN;
                end else begin
                    cnt_next = cnt_reg + IDX_W'(1);
                end
            end
            ST_DRAIN: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!out_hold) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            pole_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pole_reg  <= pole_next;
        end
    end

    assign tap_idx = cnt_reg;

endmodule

// ===== hw/rtl/iirdf_datapath.sv =====
// ----------------------------------------------------------------------------
// iirdf_datapath
// Histories, coefficients, shared multiplier, saturating accumulator and
// the output register.
// ----------------------------------------------------------------------------
module iirdf_datapath
    import iirdf_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF,
    localparam int IDX_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  ctrl_cmd_t          cmd,
    input  logic [IDX_W-1:0]   tap_idx,
    input  logic [IDX_W-1:0]   nz_eff,
    input  logic [IDX_W-1:0]   np_eff,
    input  logic signed [31:0] inv_gain,
    input  logic signed [23:0] sample_in,
    input  logic [3:0]         coef_index,
    input  logic signed [31:0] coef_value,
    input  logic               m_ready,
    output logic               out_hold,
    output logic               m_valid,
    output logic signed [23:0] m_sample_out,
    output logic               m_saturated
);

    localparam int EXT_W = IDX_W + 4;

    logic [31:0] ih_reg [MAX_ORDER];
    logic [31:0] oh_reg [MAX_ORDER];
    logic [31:0] zc_reg [MAX_ORDER];
    logic [31:0] pc_reg [MAX_ORDER];
    logic [31:0] ih_up  [MAX_ORDER];
    logic [31:0] oh_up  [MAX_ORDER];

    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_res;
    logic [63:0]        prod_reg;
    logic               prod_tap_reg;
    logic [63:0]        acc_reg, acc_next;
    logic [64:0]        acc_sum;
    logic [41:0]        sc_rnd, hist_rnd;
    logic [39:0]        out_rnd;
    logic [31:0]        x_scaled, y_hist;
    logic [23:0]        y_out;
    logic               y_clip;
    logic [EXT_W-1:0]   coef_ext;
    logic               coef_ok;
    logic [IDX_W-1:0]   coef_addr;
    logic               out_valid_reg;
    logic [23:0]        sample_out_reg;
    logic               sat_reg;

    function automatic logic [31:0] sat32(input logic [41:0] v);
        logic [31:0] r;
        if (v[41:31] == {11{v[41]}}) begin
            r = v[31:0];
        end else if (v[41]) begin
            r = 32'h8000_0000;
        end else begin
            r = 32'h7fff_ffff;
        end
        return r;
    endfunction

    always_comb begin
        if (cmd.tap_mul) begin
            if (cmd.tap_sel_pole) begin
                mul_a = pc_reg[tap_idx];
                mul_b = oh_reg[tap_idx];
            end else begin
                mul_a = zc_reg[tap_idx];
                mul_b = ih_reg[tap_idx];
            end
        end else begin
            mul_a = 32'(sample_in);
            mul_b = inv_gain;
        end
    end

    assign mul_res = mul_a * mul_b;

    always_ff @(posedge aclk) begin
        if (cmd.scale_mul || cmd.tap_mul) begin
            prod_reg <= mul_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_tap_reg <= 1'b0;
        end else begin
            prod_tap_reg <= cmd.tap_mul;
        end
    end

    // The accumulator sticks at the 64-bit limits rather than wrapping.
    assign acc_sum  = {acc_reg[63], acc_reg} + {prod_reg[63], prod_reg};
    assign acc_next = (acc_sum[64] == acc_sum[63]) ? acc_sum[63:0]
                    : (acc_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}});

    always_ff @(posedge aclk) begin
        if (cmd.acc_clear) begin
            acc_reg <= '0;
        end else if (prod_tap_reg) begin
            acc_reg <= acc_next;
        end
    end

    // Round half up: drop the fraction and add the first discarded bit.
    assign sc_rnd   = {prod_reg[63], prod_reg[63:23]} + 42'(prod_reg[22]);
    assign x_scaled = sat32(sc_rnd);
    assign hist_rnd = {{2{acc_reg[63]}}, acc_reg[63:24]} + 42'(acc_reg[23]);
    assign y_hist   = sat32(hist_rnd);
    assign out_rnd  = {acc_reg[63], acc_reg[63:25]} + 40'(acc_reg[24]);

    always_comb begin
        if (out_rnd[39:23] == {17{out_rnd[39]}}) begin
            y_out  = out_rnd[23:0];
            y_clip = 1'b0;
        end else begin
            y_out  = out_rnd[39] ? 24'h80_0000 : 24'h7f_ffff;
            y_clip = 1'b1;
        end
    end

    assign coef_ext  = EXT_W'(coef_index);
    assign coef_ok   = coef_ext < EXT_W'(MAX_ORDER);
    assign coef_addr = coef_ext[IDX_W-1:0];

    for (genvar g = 0; g < MAX_ORDER; g++) begin : g_tap
        localparam logic [IDX_W-1:0] POS = IDX_W'(g);

        if (g < MAX_ORDER - 1) begin : g_up
            assign ih_up[g] = ih_reg[g+1];
            assign oh_up[g] = oh_reg[g+1];
        end else begin : g_last
            assign ih_up[g] = '0;
            assign oh_up[g] = '0;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn || cmd.hist_clear) begin
                ih_reg[g] <= '0;
            end else if (cmd.shift_hist) begin
                if (POS < nz_eff) begin
                    ih_reg[g] <= ih_up[g];
                end else if (POS == nz_eff) begin
                    ih_reg[g] <= x_scaled;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn || cmd.hist_clear) begin
                oh_reg[g] <= '0;
            end else if (cmd.shift_hist && (POS < np_eff)) begin
                oh_reg[g] <= oh_up[g];
            end else if (cmd.finish && (POS == np_eff)) begin
                oh_reg[g] <= y_hist;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                zc_reg[g] <= '0;
            end else if (cmd.zero_wr && coef_ok && (coef_addr == POS)) begin
                zc_reg[g] <= coef_value;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                pc_reg[g] <= '0;
            end else if (cmd.pole_wr && coef_ok && (coef_addr == POS)) begin
                pc_reg[g] <= coef_value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            sample_out_reg <= y_out;
            sat_reg        <= y_clip;
        end
    end

    assign out_hold     = out_valid_reg && !m_ready;
    assign m_valid      = out_valid_reg;
    assign m_sample_out = sample_out_reg;
    assign m_saturated  = sat_reg;

endmodule

// ===== hw/rtl/iir_filter_direct_form_top.sv =====
// A sample transaction steps through the shift, tap, drain and finish states before its
// result is registered; the taps pass one per cycle through one multiplier.
// No new transaction is taken while a sample is in progress; its finish waits while the previous result is held.
// Coefficient writes and history clears are taken one per cycle while no sample is in progress and give no result.
// Reset is synchronous and active low; it restores the register defaults and clears the
// histories and coefficients at once.
// ----------------------------------------------------------------------------
// iir_filter_direct_form_top
// Direct-form I IIR filter in fixed point with one shared multiply-accumulate
// unit, driven by a sequencer.
// ----------------------------------------------------------------------------
module iir_filter_direct_form_top
    import iirdf_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_opcode,
    input  logic signed [23:0]    s_sample_in,
    input  logic [3:0]            s_coef_index,
    input  logic signed [31:0]    s_coef_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [23:0]    m_sample_out,
    output logic                  m_saturated
);

    localparam int IDX_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

    logic [IDX_W-1:0]   nz_eff;
    logic [IDX_W-1:0]   np_eff;
    logic signed [31:0] inv_gain;
    logic               out_hold;
    ctrl_cmd_t          cmd;
    logic [IDX_W-1:0]   tap_idx;

    iirdf_cfg_regs #(
        .MAX_ORDER(MAX_ORDER)
    ) u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .nz_eff   (nz_eff),
        .np_eff   (np_eff),
        .inv_gain (inv_gain)
    );

    iirdf_ctrl #(
        .MAX_ORDER(MAX_ORDER)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .opcode  (s_opcode),
        .nz_eff  (nz_eff),
        .np_eff  (np_eff),
        .out_hold(out_hold),
        .cmd     (cmd),
        .tap_idx (tap_idx)
    );

    iirdf_datapath #(
        .MAX_ORDER(MAX_ORDER)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .tap_idx     (tap_idx),
        .nz_eff      (nz_eff),
        .np_eff      (np_eff),
        .inv_gain    (inv_gain),
        .sample_in   (s_sample_in),
        .coef_index  (s_coef_index),
        .coef_value  (s_coef_value),
        .m_ready     (m_ready),
        .out_hold    (out_hold),
        .m_valid     (m_valid),
        .m_sample_out(m_sample_out),
        .m_saturated (m_saturated)
    );

endmodule

// ===== hw/rtl/iirdf_checker.sv =====
// ----------------------------------------------------------------------------
// iirdf_checker
// Port-level checks of the filter block, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module iirdf_checker
    import iirdf_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_data,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic [1:0]            s_opcode,
    input logic signed [23:0]    s_sample_in,
    input logic [3:0]            s_coef_index,
    input logic signed [31:0]    s_coef_value,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic signed [23:0]    m_sample_out,
    input logic                  m_saturated
);

    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_sample_out) && $stable(m_saturated), "Result changed while stalled")
    `ASSERT_CLK(a_sat_value, aclk, aresetn, (m_valid && m_saturated) |-> ((m_sample_out == 24'sh7fffff) || (m_sample_out == -24'sh800000)), "Saturation flag without a clipped value")
    `ASSERT_NEXT(a_sample_busy, aclk, aresetn, s_valid && s_ready && (s_opcode == OP_SAMPLE), !s_ready, "Sample transaction did not occupy the block")
    `ASSERT_NEXT(a_cmd_ready, aclk, aresetn, s_valid && s_ready && (s_opcode != OP_SAMPLE), s_ready, "Command transaction stalled the input")
    `ASSERT_CLK(a_result_src, aclk, aresetn, $rose(m_valid) |-> $past(!s_ready), "Result appeared while the block was idle")

endmodule

bind iir_filter_direct_form_top iirdf_checker u_checker (.*);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the direct-form IIR filter. A scoreboard class keeps
// its own fixed-point copy of the filter state, predicts the output of every
// accepted sample transaction and compares each accepted result field by field
// in order. Directed transactions cover the sample and coefficient extremes,
// every opcode, history clears and register corners; random phases then
// reprogram the orders, gain and coefficients between bursts of traffic.
// ----------------------------------------------------------------------------
module testbench;
    import iirdf_pkg::*;

    localparam int ORDER         = MAX_ORDER_DEF;
    localparam int RANDOM_ITEMS  = 1800;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 5000;

    typedef logic signed [31:0] word_t;
    typedef logic signed [63:0] wide_t;

    typedef struct {
        logic signed [23:0] sample_out;
        logic               saturated;
    } filter_out_t;

    class iir_scoreboard;
        logic [3:0]  num_zeros;
        logic [3:0]  num_poles;
        word_t       inv_gain;
        word_t       in_hist[ORDER];
        word_t       out_hist[ORDER];
        word_t       zero_coef[ORDER];
        word_t       pole_coef[ORDER];
        filter_out_t expected_outputs[$];
        int          errors;

        function new();
            num_zeros = '0;
            num_poles = '0;
            inv_gain  = INV_GAIN_RESET;
            errors    = 0;
            for (int i = 0; i < ORDER; i++) begin
                in_hist[i]   = '0;
                out_hist[i]  = '0;
                zero_coef[i] = '0;
                pole_coef[i] = '0;
            end
        endfunction

        static function wide_t round_half_up(wide_t v, int sh);
            wide_t r;
            r = v >>> sh;
            r = r + wide_t'(v[sh-1]);
            return r;
        endfunction

        static function word_t to_word(wide_t v);
            if (v > 64'sd2147483647) begin
                return 32'sh7FFF_FFFF;
            end
            if (v < -64'sd2147483648) begin
                return 32'sh8000_0000;
            end
            return word_t'(v);
        endfunction

        static function wide_t sat_accumulate(wide_t acc, wide_t p);
            logic signed [64:0] s;
            s = acc + p;
            if (s[64:63] == 2'b01) begin
                return {1'b0, {63{1'b1}}};
            end
            if (s[64:63] == 2'b10) begin
                return {1'b1, {63{1'b0}}};
            end
            return s[63:0];
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_NUM_ZEROS: num_zeros = data[3:0];
                REG_NUM_POLES: num_poles = data[3:0];
                REG_INV_GAIN:  inv_gain  = data;
                default: ;
            endcase
        endfunction

        function filter_out_t filter_sample(logic signed [23:0] smp);
            int          nz;
            int          np;
            wide_t       scaled;
            wide_t       acc;
            wide_t       prod;
            filter_out_t o;
            nz = (num_zeros > ORDER - 1) ? ORDER - 1 : int'(num_zeros);
            np = (num_poles > ORDER - 1) ? ORDER - 1 : int'(num_poles);
            scaled = smp * inv_gain;
            scaled = to_word(round_half_up(scaled, 23));
            for (int i = 0; i < nz; i++) begin
                in_hist[i] = in_hist[i+1];
            end
            in_hist[nz] = word_t'(scaled);
            for (int i = 0; i < np; i++) begin
                out_hist[i] = out_hist[i+1];
            end
            acc = '0;
            for (int i = 0; i <= nz; i++) begin
                prod = zero_coef[i] * in_hist[i];
                acc  = sat_accumulate(acc, prod);
            end
            for (int i = 0; i < np; i++) begin
                prod = pole_coef[i] * out_hist[i];
                acc  = sat_accumulate(acc, prod);
            end
            out_hist[np] = to_word(round_half_up(acc, 24));
            acc = round_half_up(acc, 25);
            if (acc > 64'sd8388607) begin
                o.sample_out = 24'sh7F_FFFF;
                o.saturated  = 1'b1;
            end else if (acc < -64'sd8388608) begin
                o.sample_out = 24'sh80_0000;
                o.saturated  = 1'b1;
            end else begin
                o.sample_out = acc[23:0];
                o.saturated  = 1'b0;
            end
            return o;
        endfunction

        function void note_item(opcode_t op, logic signed [23:0] smp, logic [3:0] idx,
                                word_t val);
            case (op)
                OP_SAMPLE: expected_outputs.push_back(filter_sample(smp));
                OP_ZERO_WR: begin
                    if (idx < ORDER) zero_coef[idx] = val;
                end
                OP_POLE_WR: begin
                    if (idx < ORDER) pole_coef[idx] = val;
                end
                OP_CLEAR: begin
                    for (int i = 0; i < ORDER; i++) begin
                        in_hist[i]  = '0;
                        out_hist[i] = '0;
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic signed [23:0] got, logic got_sat);
            filter_out_t e;
            if (expected_outputs.size() == 0) begin
                $error("sample_out: no result expected, actual %0d", got);
                errors++;
                return;
            end
            e = expected_outputs.pop_front();
            if (got !== e.sample_out) begin
                $error("sample_out: expected %0d, actual %0d", e.sample_out, got);
                errors++;
            end
            if (got_sat !== e.saturated) begin
                $error("saturated: expected %0b, actual %0b", e.saturated, got_sat);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;
    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_opcode     = '0;
    logic signed [23:0]    s_sample_in  = '0;
    logic [3:0]            s_coef_index = '0;
    logic signed [31:0]    s_coef_value = '0;
    logic                  m_valid;
    logic                  m_ready      = 1'b0;
    logic signed [23:0]    m_sample_out;
    logic                  m_saturated;

    iir_scoreboard scb;
    int            items_sent    = 0;
    int            send_idle_pct = 24;
    int            recv_idle_pct = 88;
    int            stall_count   = 0;

    iir_filter_direct_form_top dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_sample_in  (s_sample_in),
        .s_coef_index (s_coef_index),
        .s_coef_value (s_coef_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out),
        .m_saturated  (m_saturated)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Every accepted transaction is passed to the scoreboard; the watchdog only
    // counts cycles in which no channel moves anything.
    always @(posedge aclk) begin
        if (!aresetn) begin
            stall_count <= 0;
        end else begin
            if (cfg_valid && cfg_ready) scb.set_reg(cfg_index, cfg_data);
            if (s_valid && s_ready) begin
                scb.note_item(opcode_t'(s_opcode), s_sample_in, s_coef_index, s_coef_value);
            end
            if (m_valid && m_ready) scb.check_result(m_sample_out, m_saturated);
            if ((cfg_valid && cfg_ready) || (s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_count <= 0;
            end else if (stall_count >= STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end else begin
                stall_count <= stall_count + 1;
            end
        end
    end

    task automatic send_item(input opcode_t op, input logic [23:0] smp,
                             input logic [3:0] idx, input logic [31:0] val);
        if (items_sent < 620) begin
            send_idle_pct = 24;
            recv_idle_pct = 88;
        end else if (items_sent < 1220) begin
            send_idle_pct = 88;
            recv_idle_pct = 24;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_opcode     <= op;
        s_sample_in  <= smp;
        s_coef_index <= idx;
        s_coef_value <= val;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_sample(input logic [23:0] smp);
        send_item(OP_SAMPLE, smp, 4'($urandom), $urandom);
    endtask

    task automatic load_coef(input opcode_t op, input logic [3:0] idx, input logic [31:0] val);
        send_item(op, 24'($urandom), idx, val);
    endtask

    task automatic clear_history();
        send_item(OP_CLEAR, 24'($urandom), 4'($urandom), $urandom);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (scb.expected_outputs.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_coef(int unsigned sh);
        logic signed [31:0] r;
        r = $urandom;
        return r >>> sh;
    endfunction

    function automatic logic [23:0] rand_sample();
        case ($urandom_range(19))
            0: return 24'h7F_FFFF;
            1: return 24'h80_0000;
            2: return 24'h00_0000;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_order_word();
        logic [31:0] r;
        r = $urandom;
        if ($urandom_range(3) == 0) begin
            r[3:0] = ($urandom_range(1) == 0) ? 4'd0 : 4'd15;
        end
        return r;
    endfunction

    function automatic logic [31:0] rand_gain();
        logic signed [31:0] r;
        r = $urandom;
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return INV_GAIN_RESET;
            3: return 32'h0000_0000;
            default: return r >>> $urandom_range(4, 8);
        endcase
    endfunction

    initial begin
        int          goal;
        int          burst;
        int unsigned coef_shift;
        int unsigned pick;
        scb = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: single tap, unity gain.
        send_sample(24'sd1);
        load_coef(OP_ZERO_WR, 4'd0, INV_GAIN_RESET);
        send_sample(24'h7F_FFFF);
        send_sample(24'h80_0000);
        send_sample(24'h00_0000);
        send_sample(24'hFF_FFFF);
        load_coef(OP_ZERO_WR, 4'd0, 32'h7FFF_FFFF);
        send_sample(24'h7F_FFFF);
        send_sample(24'h80_0000);
        settle();

        // Full order, largest gain, writes to unmapped registers.
        write_reg(REG_NUM_ZEROS, 32'hFFFF_FFFF);
        write_reg(REG_NUM_POLES, 32'hFFFF_FFFF);
        write_reg(REG_INV_GAIN, 32'h7FFF_FFFF);
        write_reg(8'hFF, 32'hFFFF_FFFF);
        write_reg(REG_INV_GAIN + 8'd1, 32'h0000_0000);
        load_coef(OP_ZERO_WR, 4'd15, 32'h8000_0000);
        load_coef(OP_POLE_WR, 4'd0, 32'h8000_0000);
        load_coef(OP_POLE_WR, 4'd15, 32'h7FFF_FFFF);
        send_sample(24'h7F_FFFF);
        send_sample(24'h80_0000);
        clear_history();
        send_sample(24'sd12345);
        settle();

        // Most negative gain with the orders back at zero.
        write_reg(REG_INV_GAIN, 32'h8000_0000);
        write_reg(REG_NUM_ZEROS, 32'h0000_0000);
        write_reg(REG_NUM_POLES, 32'h0000_0000);
        send_sample(24'h7F_FFFF);
        send_sample(24'h80_0000);
        clear_history();
        send_sample(24'h80_0000);

        goal = items_sent + RANDOM_ITEMS;
        while (items_sent < goal) begin
            settle();
            if ($urandom_range(3) != 0) write_reg(REG_NUM_ZEROS, rand_order_word());
            if ($urandom_range(3) != 0) write_reg(REG_NUM_POLES, rand_order_word());
            if ($urandom_range(3) != 0) write_reg(REG_INV_GAIN, rand_gain());
            if ($urandom_range(5) == 0) begin
                write_reg(CFG_IDX_W'($urandom_range(3, 255)), $urandom);
            end
            coef_shift = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 12);
            if ($urandom_range(1) == 0) begin
                for (int i = 0; i < ORDER; i++) begin
                    load_coef(OP_ZERO_WR, 4'(i), rand_coef(coef_shift));
                    load_coef(OP_POLE_WR, 4'(i), rand_coef(coef_shift + 2));
                end
            end
            burst = $urandom_range(40, 160);
            repeat (burst) begin
                pick = $urandom_range(99);
                if (pick < 82) begin
                    send_sample(rand_sample());
                end else if (pick < 90) begin
                    load_coef(OP_ZERO_WR, 4'($urandom), rand_coef(coef_shift));
                end else if (pick < 97) begin
                    load_coef(OP_POLE_WR, 4'($urandom), rand_coef(coef_shift + 2));
                end else begin
                    clear_history();
                end
            end
        end

        settle();
        if (scb.errors == 0 && scb.expected_outputs.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
